// ===== design/ecomp_pkg.sv =====
// Package for the environment sensor compensation unit.
// Holds payload, coefficient and microcode types, codes and the microcode ROM.
// No dependencies.
`default_nettype none

package ecomp_pkg;

   localparam logic [1:0] SEL_TEMP  = 2'd0;
   localparam logic [1:0] SEL_PRESS = 2'd1;
   localparam logic [1:0] SEL_HUM   = 2'd2;
   localparam logic [1:0] SEL_NONE  = 2'd3;

   localparam logic [2:0] CSR_TEMP       = 3'd0;
   localparam logic [2:0] CSR_PRESS_LOW  = 3'd1;
   localparam logic [2:0] CSR_PRESS_HIGH = 3'd2;
   localparam logic [2:0] CSR_PRESS_NINE = 3'd3;
   localparam logic [2:0] CSR_HUM        = 3'd4;

   localparam int PC_WIDTH = 7;
   localparam logic [PC_WIDTH-1:0] PC_TEMP  = 7'd0;
   localparam logic [PC_WIDTH-1:0] PC_PRESS = 7'd16;
   localparam logic [PC_WIDTH-1:0] PC_HUM   = 7'd59;
   localparam logic [PC_WIDTH-1:0] PC_NONE  = 7'd88;

   typedef struct packed {
      logic [1:0]  op;
      logic [19:0] raw_reading;
   } ecomp_req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        zero_divisor;
   } ecomp_rsp_type;

   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } ecomp_coef_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] value;
      logic        zero;
   } ecomp_res_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_EXEC, ST_DIV_WAIT, ST_DONE
   } ecomp_state_type;

   typedef enum logic [3:0] {
      UOP_ADD, UOP_SUB, UOP_MUL, UOP_ASR, UOP_LSR, UOP_SHL,
      UOP_PRE, UOP_DBL, UOP_CLMP, UOP_DIV, UOP_ZCHK, UOP_END
   } ecomp_uop_code_type;

   typedef enum logic [4:0] {
      SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7,
      SRC_T1, SRC_T2, SRC_T3,
      SRC_P1, SRC_P2, SRC_P3, SRC_P4, SRC_P5, SRC_P6, SRC_P7, SRC_P8, SRC_P9,
      SRC_H1, SRC_H2, SRC_H3, SRC_H4, SRC_H5, SRC_H6,
      SRC_ADC, SRC_FINE, SRC_IMM
   } ecomp_src_type;

   typedef struct packed {
      ecomp_uop_code_type code;
      logic [2:0]         dst;
      ecomp_src_type      sa;
      ecomp_src_type      sb;
      logic [4:0]         sh;
      logic [31:0]        imm;
      logic               wf;
   } ecomp_uop_type;

   function automatic ecomp_uop_type uop(input ecomp_uop_code_type code,
                                         input ecomp_src_type dst,
                                         input ecomp_src_type sa,
                                         input ecomp_src_type sb,
                                         input logic [4:0] sh,
                                         input logic [31:0] imm);
      ecomp_uop_type r;
      r.code = code;
      r.dst  = dst[2:0];
      r.sa   = sa;
      r.sb   = sb;
      r.sh   = sh;
      r.imm  = imm;
      r.wf   = 1'b0;
      return r;
   endfunction

   function automatic ecomp_uop_type ecomp_ucode(input logic [PC_WIDTH-1:0] pc);
      ecomp_uop_type r;
      r = uop(UOP_END, SRC_R0, SRC_IMM, SRC_IMM, 5'd0, 32'd0);
      case (pc)
         // temperature
         7'd0:  r = uop(UOP_LSR, SRC_R0, SRC_ADC, SRC_IMM, 5'd3, 32'd0);
         7'd1:  r = uop(UOP_SHL, SRC_R1, SRC_T1, SRC_IMM, 5'd1, 32'd0);
         7'd2:  r = uop(UOP_SUB, SRC_R0, SRC_R0, SRC_R1, 5'd0, 32'd0);
         7'd3:  r = uop(UOP_MUL, SRC_R0, SRC_R0, SRC_T2, 5'd0, 32'd0);
         7'd4:  r = uop(UOP_ASR, SRC_R0, SRC_R0, SRC_IMM, 5'd11, 32'd0);
         7'd5:  r = uop(UOP_LSR, SRC_R1, SRC_ADC, SRC_IMM, 5'd4, 32'd0);
         7'd6:  r = uop(UOP_SUB, SRC_R1, SRC_R1, SRC_T1, 5'd0, 32'd0);
         7'd7:  r = uop(UOP_MUL, SRC_R1, SRC_R1, SRC_R1, 5'd0, 32'd0);
         7'd8:  r = uop(UOP_ASR, SRC_R1, SRC_R1, SRC_IMM, 5'd12, 32'd0);
         7'd9:  r = uop(UOP_MUL, SRC_R1, SRC_R1, SRC_T3, 5'd0, 32'd0);
         7'd10: r = uop(UOP_ASR, SRC_R1, SRC_R1, SRC_IMM, 5'd14, 32'd0);
         7'd11: begin
            r = uop(UOP_ADD, SRC_R0, SRC_R0, SRC_R1, 5'd0, 32'd0);
            r.wf = 1'b1;
         end
         7'd12: r = uop(UOP_MUL, SRC_R0, SRC_R0, SRC_IMM, 5'd0, 32'd5);
         7'd13: r = uop(UOP_ADD, SRC_R0, SRC_R0, SRC_IMM, 5'd0, 32'd128);
         7'd14: r = uop(UOP_ASR, SRC_R0, SRC_R0, SRC_IMM, 5'd8, 32'd0);
         7'd15: r = uop(UOP_END, SRC_R0, SRC_R0, SRC_IMM, 5'd0, 32'd0);
         // pressure
         7'd16: r = uop(UOP_ASR, SRC_R0, SRC_FINE, SRC_IMM, 5'd1, 32'd0);
         7'd17: r = uop(UOP_SUB, SRC_R0, SRC_R0, SRC_IMM, 5'd0, 32'd64000);
         7'd18: r = uop(UOP_ASR, SRC_R1, SRC_R0, SRC_IMM, 5'd2, 32'd0);
         7'd19: r = uop(UOP_MUL, SRC_R1, SRC_R1, SRC_R1, 5'd0, 32'd0);
         7'd20: r = uop(UOP_ASR, SRC_R2, SRC_R1, SRC_IMM, 5'd11, 32'd0);
         7'd21: r = uop(UOP_MUL, SRC_R2, SRC_R2, SRC_P6, 5'd0, 32'd0);
         7'd22: r = uop(UOP_MUL, SRC_R3, SRC_R0, SRC_P5, 5'd0, 32'd0);
         7'd23: r = uop(UOP_SHL, SRC_R3, SRC_R3, SRC_IMM, 5'd1, 32'd0);
         7'd24: r = uop(UOP_ADD, SRC_R2, SRC_R2, SRC_R3, 5'd0, 32'd0);
         7'd25: r = uop(UOP_ASR, SRC_R2, SRC_R2, SRC_IMM, 5'd2, 32'd0);
         7'd26: r = uop(UOP_SHL, SRC_R3, SRC_P4, SRC_IMM, 5'd16, 32'd0);
         7'd27: r = uop(UOP_ADD, SRC_R2, SRC_R2, SRC_R3, 5'd0, 32'd0);
         7'd28: r = uop(UOP_ASR, SRC_R3, SRC_R1, SRC_IMM, 5'd13, 32'd0);
         7'd29: r = uop(UOP_MUL, SRC_R3, SRC_P3, SRC_R3, 5'd0, 32'd0);
         7'd30: r = uop(UOP_ASR, SRC_R3, SRC_R3, SRC_IMM, 5'd3, 32'd0);
         7'd31: r = uop(UOP_MUL, SRC_R4, SRC_P2, SRC_R0, 5'd0, 32'd0);
         7'd32: r = uop(UOP_ASR, SRC_R4, SRC_R4, SRC_IMM, 5'd1, 32'd0);
         7'd33: r = uop(UOP_ADD, SRC_R3, SRC_R3, SRC_R4, 5'd0, 32'd0);
         7'd34: r = uop(UOP_ASR, SRC_R3, SRC_R3, SRC_IMM, 5'd18, 32'd0);
         7'd35: r = uop(UOP_ADD, SRC_R3, SRC_R3, SRC_IMM, 5'd0, 32'd32768);
         7'd36: r = uop(UOP_MUL, SRC_R3, SRC_R3, SRC_P1, 5'd0, 32'd0);
         7'd37: r = uop(UOP_ASR, SRC_R3, SRC_R3, SRC_IMM, 5'd15, 32'd0);
         7'd38: r = uop(UOP_ZCHK, SRC_R3, SRC_R3, SRC_IMM, 5'd0, 32'd0);
         7'd39: r = uop(UOP_SUB, SRC_R4, SRC_IMM, SRC_ADC, 5'd0, 32'd1048576);
         7'd40: r = uop(UOP_ASR, SRC_R5, SRC_R2, SRC_IMM, 5'd12, 32'd0);
         7'd41: r = uop(UOP_SUB, SRC_R4, SRC_R4, SRC_R5, 5'd0, 32'd0);
         7'd42: r = uop(UOP_MUL, SRC_R4, SRC_R4, SRC_IMM, 5'd0, 32'd3125);
         7'd43: r = uop(UOP_PRE, SRC_R5, SRC_R4, SRC_IMM, 5'd0, 32'd0);
         7'd44: r = uop(UOP_DIV, SRC_R5, SRC_R5, SRC_R3, 5'd0, 32'd0);
         7'd45: r = uop(UOP_DBL, SRC_R4, SRC_R5, SRC_R4, 5'd0, 32'd0);
         7'd46: r = uop(UOP_LSR, SRC_R5, SRC_R4, SRC_IMM, 5'd3, 32'd0);
         7'd47: r = uop(UOP_MUL, SRC_R5, SRC_R5, SRC_R5, 5'd0, 32'd0);
         7'd48: r = uop(UOP_LSR, SRC_R5, SRC_R5, SRC_IMM, 5'd13, 32'd0);
         7'd49: r = uop(UOP_MUL, SRC_R5, SRC_P9, SRC_R5, 5'd0, 32'd0);
         7'd50: r = uop(UOP_ASR, SRC_R5, SRC_R5, SRC_IMM, 5'd12, 32'd0);
         7'd51: r = uop(UOP_LSR, SRC_R6, SRC_R4, SRC_IMM, 5'd2, 32'd0);
         7'd52: r = uop(UOP_MUL, SRC_R6, SRC_R6, SRC_P8, 5'd0, 32'd0);
         7'd53: r = uop(UOP_ASR, SRC_R6, SRC_R6, SRC_IMM, 5'd13, 32'd0);
         7'd54: r = uop(UOP_ADD, SRC_R5, SRC_R5, SRC_R6, 5'd0, 32'd0);
         7'd55: r = uop(UOP_ADD, SRC_R5, SRC_R5, SRC_P7, 5'd0, 32'd0);
         7'd56: r = uop(UOP_ASR, SRC_R5, SRC_R5, SRC_IMM, 5'd4, 32'd0);
         7'd57: r = uop(UOP_ADD, SRC_R5, SRC_R4, SRC_R5, 5'd0, 32'd0);
         7'd58: r = uop(UOP_END, SRC_R5, SRC_R5, SRC_IMM, 5'd0, 32'd0);
         // humidity
         7'd59: r = uop(UOP_SUB, SRC_R0, SRC_FINE, SRC_IMM, 5'd0, 32'd76800);
         7'd60: r = uop(UOP_SHL, SRC_R1, SRC_ADC, SRC_IMM, 5'd14, 32'd0);
         7'd61: r = uop(UOP_SHL, SRC_R2, SRC_H4, SRC_IMM, 5'd20, 32'd0);
         7'd62: r = uop(UOP_SUB, SRC_R1, SRC_R1, SRC_R2, 5'd0, 32'd0);
         7'd63: r = uop(UOP_MUL, SRC_R2, SRC_H5, SRC_R0, 5'd0, 32'd0);
         7'd64: r = uop(UOP_SUB, SRC_R1, SRC_R1, SRC_R2, 5'd0, 32'd0);
         7'd65: r = uop(UOP_ADD, SRC_R1, SRC_R1, SRC_IMM, 5'd0, 32'd16384);
         7'd66: r = uop(UOP_ASR, SRC_R1, SRC_R1, SRC_IMM, 5'd15, 32'd0);
         7'd67: r = uop(UOP_MUL, SRC_R2, SRC_R0, SRC_H6, 5'd0, 32'd0);
         7'd68: r = uop(UOP_ASR, SRC_R2, SRC_R2, SRC_IMM, 5'd10, 32'd0);
         7'd69: r = uop(UOP_MUL, SRC_R3, SRC_R0, SRC_H3, 5'd0, 32'd0);
         7'd70: r = uop(UOP_ASR, SRC_R3, SRC_R3, SRC_IMM, 5'd11, 32'd0);
         7'd71: r = uop(UOP_ADD, SRC_R3, SRC_R3, SRC_IMM, 5'd0, 32'd32768);
         7'd72: r = uop(UOP_MUL, SRC_R2, SRC_R2, SRC_R3, 5'd0, 32'd0);
         7'd73: r = uop(UOP_ASR, SRC_R2, SRC_R2, SRC_IMM, 5'd10, 32'd0);
         7'd74: r = uop(UOP_ADD, SRC_R2, SRC_R2, SRC_IMM, 5'd0, 32'd2097152);
         7'd75: r = uop(UOP_MUL, SRC_R2, SRC_R2, SRC_H2, 5'd0, 32'd0);
         7'd76: r = uop(UOP_ADD, SRC_R2, SRC_R2, SRC_IMM, 5'd0, 32'd8192);
         7'd77: r = uop(UOP_ASR, SRC_R2, SRC_R2, SRC_IMM, 5'd14, 32'd0);
         7'd78: r = uop(UOP_MUL, SRC_R1, SRC_R1, SRC_R2, 5'd0, 32'd0);
         7'd79: r = uop(UOP_ASR, SRC_R2, SRC_R1, SRC_IMM, 5'd15, 32'd0);
         7'd80: r = uop(UOP_MUL, SRC_R2, SRC_R2, SRC_R2, 5'd0, 32'd0);
         7'd81: r = uop(UOP_ASR, SRC_R2, SRC_R2, SRC_IMM, 5'd7, 32'd0);
         7'd82: r = uop(UOP_MUL, SRC_R2, SRC_R2, SRC_H1, 5'd0, 32'd0);
         7'd83: r = uop(UOP_ASR, SRC_R2, SRC_R2, SRC_IMM, 5'd4, 32'd0);
         7'd84: r = uop(UOP_SUB, SRC_R1, SRC_R1, SRC_R2, 5'd0, 32'd0);
         7'd85: r = uop(UOP_CLMP, SRC_R1, SRC_R1, SRC_IMM, 5'd0, 32'd419430400);
         7'd86: r = uop(UOP_LSR, SRC_R1, SRC_R1, SRC_IMM, 5'd12, 32'd0);
         7'd87: r = uop(UOP_END, SRC_R1, SRC_R1, SRC_IMM, 5'd0, 32'd0);
         // unused selector
         7'd88: r = uop(UOP_END, SRC_R0, SRC_IMM, SRC_IMM, 5'd0, 32'd0);
         default: r = uop(UOP_END, SRC_R0, SRC_IMM, SRC_IMM, 5'd0, 32'd0);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/ecomp_alu.sv =====
// Shared 32-bit ALU: add, subtract, multiply, shifts, conditional doubling, clamp.
// Depends on ecomp_pkg.
`default_nettype none

module ecomp_alu
   import ecomp_pkg::*;
(
   input  ecomp_uop_code_type code,
   input  logic [31:0]        a,
   input  logic [31:0]        b,
   input  logic [4:0]         sh,
   output logic [31:0]        y
);

   logic [63:0] prod;

   assign prod = a * b;

   always_comb begin
      case (code)
         UOP_ADD:  y = a + b;
         UOP_SUB:  y = a - b;
         UOP_MUL:  y = prod[31:0];
         UOP_ASR:  y = $unsigned($signed(a) >>> sh);
         UOP_LSR:  y = a >> sh;
         UOP_SHL:  y = a << sh;
         UOP_PRE:  y = a[31] ? a : {a[30:0], 1'b0};
         UOP_DBL:  y = b[31] ? {a[30:0], 1'b0} : a;
         UOP_CLMP: y = a[31] ? 32'd0 : ((a > b) ? b : a);
         default:  y = a;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/ecomp_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// No dependencies; it does not import ecomp_pkg.
`default_nettype none

module ecomp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = 32'd0;
         quo_in  = dividend;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/ecomp_seq.sv =====
// Microcode sequencer with scratch register file and fine temperature.
// Depends on ecomp_pkg, ecomp_alu and ecomp_div.
`default_nettype none

module ecomp_seq
   import ecomp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [1:0]     op,
   input  logic [19:0]    adc,
   input  ecomp_coef_type coef,
   input  logic           take,
   output logic           idle,
   output ecomp_res_type  res
);

   ecomp_state_type       state_ff, state_in;
   logic [PC_WIDTH-1:0]   pc_ff, pc_in;
   logic [19:0]           adc_ff;
   logic [31:0]           fine_ff;
   logic [31:0]           a_ff, b_ff;
   logic [31:0]           val_ff, val_in;
   logic                  zero_ff, zero_in;
   logic [31:0]           rf_ff [8];
   logic                  rf_we, fine_we, div_start, div_done;
   logic [31:0]           rf_wdata, alu_y, div_q, ext_a, ext_b;
   logic [PC_WIDTH-1:0]   start_pc;
   ecomp_uop_type         u;

   function automatic logic [31:0] ext_val(input ecomp_src_type s,
                                           input ecomp_coef_type c,
                                           input logic [19:0] adc_v,
                                           input logic [31:0] fine_v,
                                           input logic [31:0] imm);
      logic [31:0] v;
      case (s)
         SRC_T1:   v = c.t1;
         SRC_T2:   v = c.t2;
         SRC_T3:   v = c.t3;
         SRC_P1:   v = c.p1;
         SRC_P2:   v = c.p2;
         SRC_P3:   v = c.p3;
         SRC_P4:   v = c.p4;
         SRC_P5:   v = c.p5;
         SRC_P6:   v = c.p6;
         SRC_P7:   v = c.p7;
         SRC_P8:   v = c.p8;
         SRC_P9:   v = c.p9;
         SRC_H1:   v = c.h1;
         SRC_H2:   v = c.h2;
         SRC_H3:   v = c.h3;
         SRC_H4:   v = c.h4;
         SRC_H5:   v = c.h5;
         SRC_H6:   v = c.h6;
         SRC_ADC:  v = {12'd0, adc_v};
         SRC_FINE: v = fine_v;
         default:  v = imm;
      endcase
      return v;
   endfunction

   assign u     = ecomp_ucode(pc_ff);
   assign ext_a = ext_val(u.sa, coef, adc_ff, fine_ff, u.imm);
   assign ext_b = ext_val(u.sb, coef, adc_ff, fine_ff, u.imm);

   always_comb begin
      case (op)
         SEL_TEMP:  start_pc = PC_TEMP;
         SEL_PRESS: start_pc = PC_PRESS;
         SEL_HUM:   start_pc = PC_HUM;
         default:   start_pc = PC_NONE;
      endcase
   end

   ecomp_alu u_alu (
      .code (u.code),
      .a    (a_ff),
      .b    (b_ff),
      .sh   (u.sh),
      .y    (alu_y)
   );

   ecomp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      val_in    = val_ff;
      zero_in   = zero_ff;
      rf_we     = 1'b0;
      rf_wdata  = alu_y;
      fine_we   = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pc_in    = start_pc;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (u.code)
               UOP_DIV: begin
                  div_start = 1'b1;
                  state_in  = ST_DIV_WAIT;
               end
               UOP_ZCHK: begin
                  if (a_ff == 32'd0) begin
                     val_in   = 32'd0;
                     zero_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     pc_in    = pc_ff + 7'd1;
                     state_in = ST_FETCH;
                  end
               end
               UOP_END: begin
                  val_in   = a_ff;
                  zero_in  = 1'b0;
                  state_in = ST_DONE;
               end
               default: begin
                  rf_we    = 1'b1;
                  fine_we  = u.wf;
                  pc_in    = pc_ff + 7'd1;
                  state_in = ST_FETCH;
               end
            endcase
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rf_we    = 1'b1;
               rf_wdata = div_q;
               pc_in    = pc_ff + 7'd1;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= PC_TEMP;
         fine_ff  <= 32'd0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (fine_we) begin
            fine_ff <= alu_y;
         end
      end
      val_ff  <= val_in;
      zero_ff <= zero_in;
      if (state_ff == ST_IDLE && start) begin
         adc_ff <= adc;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_ff[u.dst] <= rf_wdata;
      end
      if (state_ff == ST_FETCH) begin
         a_ff <= (u.sa <= SRC_R7) ? rf_ff[u.sa[2:0]] : ext_a;
         b_ff <= (u.sb <= SRC_R7) ? rf_ff[u.sb[2:0]] : ext_b;
      end
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res.valid = (state_ff == ST_DONE);
   assign res.value = val_ff;
   assign res.zero  = zero_ff;

endmodule

`default_nettype wire

// ===== design/environment_sensor_compensation_unit.sv =====
// Top level of the environment sensor compensation unit: CSRs, handshakes,
// result register. Depends on ecomp_pkg and ecomp_seq.
//
//  Channel  Direction  Handshake           Payload
//  req      in         req_valid/stall     ecomp_req_type (op, raw_reading)
//  rsp      out        rsp_valid/stall     ecomp_rsp_type (value, zero_divisor)
//  csr      in         csr_valid/ready     csr_index, csr_data
//
// Each microcode step passes through a fetch state and an execute state on one
// ALU; a divide waits in ST_DIV_WAIT. req_stall is high from accept until
// the result moves to the output register. Reset clears the CSRs, the fine
// temperature and all control; a stalled result holds while a new item runs.
`default_nettype none

module environment_sensor_compensation_unit
   import ecomp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ecomp_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ecomp_rsp_type rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data
);

   logic [47:0]    temp_ff;
   logic [63:0]    plow_ff, phigh_ff, hum_ff;
   logic [15:0]    p9_ff;
   logic           rsp_valid_ff;
   ecomp_rsp_type  rsp_data_ff;
   logic           idle, start, take;
   logic [19:0]    adc;
   ecomp_coef_type coef;
   ecomp_res_type  res;

   assign csr_ready = 1'b1;
   assign req_stall = !idle;
   assign start     = req_valid && idle;
   assign take      = !rsp_valid_ff || !rsp_stall;
   assign adc       = (req_data.op == SEL_HUM) ? {4'd0, req_data.raw_reading[15:0]}
                                                : req_data.raw_reading;

   assign coef.t1 = {16'd0, temp_ff[15:0]};
   assign coef.t2 = {{16{temp_ff[31]}}, temp_ff[31:16]};
   assign coef.t3 = {{16{temp_ff[47]}}, temp_ff[47:32]};
   assign coef.p1 = {16'd0, plow_ff[15:0]};
   assign coef.p2 = {{16{plow_ff[31]}}, plow_ff[31:16]};
   assign coef.p3 = {{16{plow_ff[47]}}, plow_ff[47:32]};
   assign coef.p4 = {{16{plow_ff[63]}}, plow_ff[63:48]};
   assign coef.p5 = {{16{phigh_ff[15]}}, phigh_ff[15:0]};
   assign coef.p6 = {{16{phigh_ff[31]}}, phigh_ff[31:16]};
   assign coef.p7 = {{16{phigh_ff[47]}}, phigh_ff[47:32]};
   assign coef.p8 = {{16{phigh_ff[63]}}, phigh_ff[63:48]};
   assign coef.p9 = {{16{p9_ff[15]}}, p9_ff};
   assign coef.h1 = {24'd0, hum_ff[7:0]};
   assign coef.h2 = {{16{hum_ff[23]}}, hum_ff[23:8]};
   assign coef.h3 = {24'd0, hum_ff[31:24]};
   assign coef.h4 = {{20{hum_ff[43]}}, hum_ff[43:32]};
   assign coef.h5 = {{20{hum_ff[55]}}, hum_ff[55:44]};
   assign coef.h6 = {{24{hum_ff[63]}}, hum_ff[63:56]};

   ecomp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_data.op),
      .adc   (adc),
      .coef  (coef),
      .take  (take),
      .idle  (idle),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= 48'd0;
         plow_ff  <= 64'd0;
         phigh_ff <= 64'd0;
         p9_ff    <= 16'd0;
         hum_ff   <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP:       temp_ff  <= csr_data[47:0];
            CSR_PRESS_LOW:  plow_ff  <= csr_data;
            CSR_PRESS_HIGH: phigh_ff <= csr_data;
            CSR_PRESS_NINE: p9_ff    <= csr_data[15:0];
            CSR_HUM:        hum_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid && take) begin
         rsp_data_ff.value        <= res.value;
         rsp_data_ff.zero_divisor <= res.zero;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/ecomp_checker.sv =====
// Port-level checker for the environment sensor compensation unit, and its bind.
// Depends on ecomp_pkg and environment_sensor_compensation_unit.
`default_nettype none

module ecomp_port_checker
   import ecomp_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input ecomp_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transfer changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("ready right after accepted transfer");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_divisor |-> rsp_data.value == 32'd0)
      else $error("zero divisor with nonzero value");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind environment_sensor_compensation_unit ecomp_port_checker u_ecomp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/ecomp_checker.sv =====
// Checker for the environment sensor compensation unit: watches the request,
// response and CSR transfers, predicts each compensated value and compares.
// Depends on ecomp_pkg.
`timescale 1ns / 100ps
`default_nettype none

module ecomp_checker
   import ecomp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_stall,
   input  wire ecomp_req_type req_data,
   input  wire logic          rsp_valid,
   input  wire logic          rsp_stall,
   input  wire ecomp_rsp_type rsp_data,
   input  wire logic          csr_valid,
   input  wire logic          csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [63:0]   csr_data,
   output int                 error_count,
   output int                 pending_count
);

   logic [47:0] temp_coeffs;
   logic [63:0] press_low, press_high, hum_coeffs;
   logic [15:0] press_nine;
   logic [31:0] fine_temp;
   ecomp_rsp_type expected_q[$];

   assign pending_count = expected_q.size();

   function automatic logic [31:0] sx(input logic [63:0] r, input int pos, input int w);
      logic [31:0] v;
      v = 32'(r >> pos) & ((32'd1 << w) - 1);
      return (v ^ (32'd1 << (w - 1))) - (32'd1 << (w - 1));
   endfunction

   function automatic logic [31:0] ux(input logic [63:0] r, input int pos, input int w);
      return 32'(r >> pos) & ((32'd1 << w) - 1);
   endfunction

   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      return $signed(x) >>> n;
   endfunction

   task automatic compensate(input ecomp_req_type rq, output ecomp_rsp_type rs);
      logic [31:0] adc, t1, a, b, d, v1, v2, q, p, x, s;
      adc = 32'(rq.raw_reading);
      rs = '0;
      case (rq.op)
         SEL_TEMP: begin
            t1 = ux(temp_coeffs, 0, 16);
            a = sra(((adc >> 3) - (t1 << 1)) * sx(temp_coeffs, 16, 16), 11);
            d = (adc >> 4) - t1;
            b = sra(sra(d * d, 12) * sx(temp_coeffs, 32, 16), 14);
            fine_temp = a + b;
            rs.value = sra(fine_temp * 32'd5 + 32'd128, 8);
         end
         SEL_PRESS: begin
            v1 = sra(fine_temp, 1) - 32'd64000;
            q = sra(v1, 2);
            q = q * q;
            v2 = sra(q, 11) * sx(press_high, 16, 16);
            v2 = v2 + ((v1 * sx(press_high, 0, 16)) << 1);
            v2 = sra(v2, 2) + (sx(press_low, 48, 16) << 16);
            v1 = sra(sra(sx(press_low, 32, 16) * sra(q, 13), 3)
                     + sra(sx(press_low, 16, 16) * v1, 1), 18);
            v1 = sra((32'd32768 + v1) * ux(press_low, 0, 16), 15);
            if (v1 == 0) begin
               rs.zero_divisor = 1'b1;
            end else begin
               p = ((32'd1048576 - adc) - sra(v2, 12)) * 32'd3125;
               if (p < 32'h8000_0000) p = (p << 1) / v1;
               else p = (p / v1) * 32'd2;
               v1 = sra(sx(64'(press_nine), 0, 16) * (((p >> 3) * (p >> 3)) >> 13), 12);
               v2 = sra((p >> 2) * sx(press_high, 48, 16), 13);
               rs.value = p + sra(v1 + v2 + sx(press_high, 32, 16), 4);
            end
         end
         SEL_HUM: begin
            adc = adc & 32'hFFFF;
            x = fine_temp - 32'd76800;
            a = sra((adc << 14) - (sx(hum_coeffs, 32, 12) << 20)
                    - sx(hum_coeffs, 44, 12) * x + 32'd16384, 15);
            b = sra(sra(x * sx(hum_coeffs, 56, 8), 10)
                    * (sra(x * ux(hum_coeffs, 24, 8), 11) + 32'd32768), 10);
            b = sra((b + 32'd2097152) * sx(hum_coeffs, 8, 16) + 32'd8192, 14);
            x = a * b;
            s = sra(x, 15);
            x = x - sra(sra(s * s, 7) * ux(hum_coeffs, 0, 8), 4);
            if (x[31]) x = 0;
            if (x > 32'd419430400) x = 32'd419430400;
            rs.value = x >> 12;
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      ecomp_rsp_type e;
      if (reset) begin
         temp_coeffs <= '0;
         press_low <= '0;
         press_high <= '0;
         press_nine <= '0;
         hum_coeffs <= '0;
         fine_temp = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEMP:       temp_coeffs <= csr_data[47:0];
               CSR_PRESS_LOW:  press_low <= csr_data;
               CSR_PRESS_HIGH: press_high <= csr_data;
               CSR_PRESS_NINE: press_nine <= csr_data[15:0];
               CSR_HUM:        hum_coeffs <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            compensate(req_data, e);
            expected_q.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report("unexpected transfer", 64'(rsp_data), 64'd0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.value !== e.value)
                  report("value", 64'(rsp_data.value), 64'(e.value));
               if (rsp_data.zero_divisor !== e.zero_divisor)
                  report("zero_divisor", 64'(rsp_data.zero_divisor), 64'(e.zero_divisor));
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the compensation unit testbench: clock, reset, CSR phases, request
// stimulus with random idling and the verdict. Depends on ecomp_pkg,
// ecomp_checker and environment_sensor_compensation_unit.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import ecomp_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ecomp_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ecomp_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;
   int error_count, pending_count;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int quiet_cycles = 0;
   bit hold_off = 1'b0;

   always #5 clock = ~clock;

   environment_sensor_compensation_unit dut (.*);

   ecomp_checker checker_i (.*);

   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send(input logic [1:0] op, input logic [19:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{op: op, raw_reading: raw};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mode 0 all zero, 1 all ones, 2 typical calibration with random spread, 3 random
   task automatic load_coeffs(input int mode);
      logic [63:0] r [5];
      for (int i = 0; i < 5; i++) r[i] = {$urandom, $urandom};
      if (mode == 0) begin
         r = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
      end else if (mode == 1) begin
         r = '{64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF};
      end else if (mode == 2) begin
         r[0] = {16'h0, 16'(-1000 + $urandom_range(2000)), 16'(26000 + $urandom_range(1000)),
                 16'(27000 + $urandom_range(2000))};
         r[1] = {16'(7000 + $urandom_range(2000)), 16'(3000 + $urandom_range(2000)),
                 16'(-10700 + $urandom_range(200)), 16'(36000 + $urandom_range(2000))};
         r[2] = {16'(-12000 + $urandom_range(200)), 16'(15500 + $urandom_range(200)),
                 16'(-7), 16'(140 + $urandom_range(20))};
         r[3] = 64'(16'(6000 + $urandom_range(200)));
         r[4] = {8'd30, 12'd50, 12'd330, 8'd0, 16'd360, 8'd75};
      end
      write_csr(CSR_TEMP, r[0]);
      write_csr(CSR_PRESS_LOW, r[1]);
      write_csr(CSR_PRESS_HIGH, r[2]);
      write_csr(CSR_PRESS_NINE, r[3]);
      write_csr(CSR_HUM, r[4]);
      csr_valid <= 1'b0;
   endtask

   task automatic random_items(input int count);
      logic [1:0] op;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(99) < 3) ? SEL_NONE : 2'($urandom_range(2));
         if ($urandom_range(3) == 0) send(op, 20'($urandom));
         else send(op, 20'(300000 + $urandom_range(300000)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(SEL_PRESS, 20'd0);
      send(SEL_HUM, 20'hFFFFF);
      send(SEL_TEMP, 20'd0);
      send(SEL_NONE, 20'hFFFFF);
      drain();
      load_coeffs(1);
      send(SEL_TEMP, 20'hFFFFF);
      send(SEL_PRESS, 20'hFFFFF);
      send(SEL_HUM, 20'h0FFFF);
      send(SEL_TEMP, 20'd0);
      send(SEL_PRESS, 20'd0);
      send(SEL_HUM, 20'd0);
      drain();
      load_coeffs(2);
      for (int i = 0; i < 4; i++) begin
         send(SEL_TEMP, 20'(500000 + 20000 * i));
         send(SEL_PRESS, 20'(400000 + 30000 * i));
         send(SEL_HUM, 20'(20000 + 10000 * i));
      end
      send(SEL_HUM, 20'd0);
      send(SEL_HUM, 20'hFFFF);
      send(SEL_NONE, 20'd12345);
      drain();
      send_idle_pct = 28;
      recv_idle_pct = 83;
      random_items(150);
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(posedge clock);
            hold_off = 1'b0;
         end
         random_items(10);
      join
      drain();
      load_coeffs(3);
      send_idle_pct = 83;
      recv_idle_pct = 28;
      random_items(120);
      drain();
      load_coeffs(2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_items(420);
      drain();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
